// File: hw/rtl/m1ice_pkg.sv
// Shared types and constants for the MIPS-I integer execute core.
// Holds the request structs, opcode codes and reset constants.
// Depends on nothing; every other file but m1ice_ram uses it.
`timescale 1ns / 1ps
`default_nettype none

package m1ice_pkg;

    typedef struct packed {
        logic        mode;
        logic [31:0] instruction;
        logic        irq_pending;
        logic [31:0] load_data;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  request_kind;
        logic [31:0] mem_address;
        logic [1:0]  access_size;
        logic [3:0]  byte_enable;
        logic [31:0] write_data;
        logic [31:0] next_pc;
        logic        exception_taken;
        logic        unknown_opcode;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic is_div;
        logic is_signed;
    } md_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] hi;
        logic [31:0] lo;
    } md_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MULDIV,
        ST_DONE
    } state_t;

    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam logic [2:0] LF_LB  = 3'd0;
    localparam logic [2:0] LF_LH  = 3'd1;
    localparam logic [2:0] LF_LWL = 3'd2;
    localparam logic [2:0] LF_LW  = 3'd3;
    localparam logic [2:0] LF_LBU = 3'd4;
    localparam logic [2:0] LF_LHU = 3'd5;
    localparam logic [2:0] LF_LWR = 3'd6;

    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_REGIMM  = 6'd1;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_BLEZ    = 6'd6;
    localparam logic [5:0] OP_BGTZ    = 6'd7;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_ADDIU   = 6'd9;
    localparam logic [5:0] OP_SLTI    = 6'd10;
    localparam logic [5:0] OP_SLTIU   = 6'd11;
    localparam logic [5:0] OP_ANDI    = 6'd12;
    localparam logic [5:0] OP_ORI     = 6'd13;
    localparam logic [5:0] OP_XORI    = 6'd14;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_COP0    = 6'd16;
    localparam logic [5:0] OP_LB      = 6'd32;
    localparam logic [5:0] OP_LH      = 6'd33;
    localparam logic [5:0] OP_LWL     = 6'd34;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_LBU     = 6'd36;
    localparam logic [5:0] OP_LHU     = 6'd37;
    localparam logic [5:0] OP_LWR     = 6'd38;
    localparam logic [5:0] OP_SB      = 6'd40;
    localparam logic [5:0] OP_SH      = 6'd41;
    localparam logic [5:0] OP_SWL     = 6'd42;
    localparam logic [5:0] OP_SW      = 6'd43;
    localparam logic [5:0] OP_SWR     = 6'd46;

    localparam logic [5:0] FN_SLL     = 6'd0;
    localparam logic [5:0] FN_SRL     = 6'd2;
    localparam logic [5:0] FN_SRA     = 6'd3;
    localparam logic [5:0] FN_SLLV    = 6'd4;
    localparam logic [5:0] FN_SRLV    = 6'd6;
    localparam logic [5:0] FN_SRAV    = 6'd7;
    localparam logic [5:0] FN_JR      = 6'd8;
    localparam logic [5:0] FN_JALR    = 6'd9;
    localparam logic [5:0] FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_BREAK   = 6'd13;
    localparam logic [5:0] FN_MFHI    = 6'd16;
    localparam logic [5:0] FN_MTHI    = 6'd17;
    localparam logic [5:0] FN_MFLO    = 6'd18;
    localparam logic [5:0] FN_MTLO    = 6'd19;
    localparam logic [5:0] FN_MULT    = 6'd24;
    localparam logic [5:0] FN_MULTU   = 6'd25;
    localparam logic [5:0] FN_DIV     = 6'd26;
    localparam logic [5:0] FN_DIVU    = 6'd27;
    localparam logic [5:0] FN_ADD     = 6'd32;
    localparam logic [5:0] FN_ADDU    = 6'd33;
    localparam logic [5:0] FN_SUB     = 6'd34;
    localparam logic [5:0] FN_SUBU    = 6'd35;
    localparam logic [5:0] FN_AND     = 6'd36;
    localparam logic [5:0] FN_OR      = 6'd37;
    localparam logic [5:0] FN_XOR     = 6'd38;
    localparam logic [5:0] FN_NOR     = 6'd39;
    localparam logic [5:0] FN_SLT     = 6'd42;
    localparam logic [5:0] FN_SLTU    = 6'd43;

    localparam logic [4:0] RT_BLTZ    = 5'd0;
    localparam logic [4:0] RT_BGEZ    = 5'd1;
    localparam logic [4:0] RT_BLTZAL  = 5'd16;
    localparam logic [4:0] RT_BGEZAL  = 5'd17;

    localparam logic [4:0] CP_MF      = 5'd0;
    localparam logic [4:0] CP_MT      = 5'd4;
    localparam logic [4:0] CP_RFE     = 5'd16;

    localparam int CP0_SR    = 12;
    localparam int CP0_CAUSE = 13;
    localparam int CP0_EPC   = 14;
    localparam int CP0_PRID  = 15;

    localparam logic [4:0]  GPR_SP      = 5'd29;
    localparam logic [4:0]  GPR_RA      = 5'd31;
    localparam logic [31:0] SP_RESET    = 32'h0000_0500;
    localparam logic [31:0] PC_RESET    = 32'hbfc0_0000;
    localparam logic [31:0] VEC_BOOT    = 32'hbfc0_0180;
    localparam logic [31:0] VEC_RAM     = 32'h8000_0080;
    localparam logic [31:0] SR_RESET    = 32'h1090_0000;
    localparam logic [31:0] PRID_RESET  = 32'h0000_0002;
    localparam logic [31:0] CAUSE_INT   = 32'h0000_0400;
    localparam logic [31:0] CAUSE_SYS   = 32'h0000_0020;
    localparam logic [31:0] CAUSE_BD    = 32'h8000_0000;

    function automatic logic [31:0] gpr_reset_value(input logic [4:0] idx);
        return (idx == GPR_SP) ? SP_RESET : 32'd0;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/m1ice_ram.sv
// Generic RAM: one write port, two registered read ports.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module m1ice_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule

`default_nettype wire

// File: hw/rtl/m1ice_muldiv.sv
// Iterative multiply/divide unit: one shared 33-bit adder, one bit per cycle.
// Depends on m1ice_pkg for the request and response structs.
`timescale 1ns / 1ps
`default_nettype none

module m1ice_muldiv (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire m1ice_pkg::md_req_t req,
    input  wire logic [31:0]       op_a,
    input  wire logic [31:0]       op_b,
    output m1ice_pkg::md_rsp_t     rsp
);
    import m1ice_pkg::*;

    logic        busy_reg, fix_reg, done_reg, div_reg, neg_hi_reg, neg_lo_reg;
    logic [4:0]  count_reg;
    logic [31:0] hi_reg, lo_reg, den_reg;
    logic [32:0] opx, opy;
    logic [33:0] sum;
    logic [31:0] mag_a, mag_b;
    logic [63:0] prod_neg;

    assign mag_a = (req.is_signed && op_a[31]) ? (32'd0 - op_a) : op_a;
    assign mag_b = (req.is_signed && op_b[31]) ? (32'd0 - op_b) : op_b;

    // Divide shifts the next dividend bit into the remainder before subtracting.
    assign opx = div_reg ? {hi_reg, lo_reg[31]} : {1'b0, hi_reg};
    assign opy = {1'b0, den_reg};
    assign sum = {1'b0, opx} + {1'b0, div_reg ? ~opy : opy} + {33'd0, div_reg};
    assign prod_neg = 64'd0 - {hi_reg, lo_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg   <= 1'b1;
                count_reg  <= 5'd0;
                div_reg    <= req.is_div;
                hi_reg     <= 32'd0;
                lo_reg     <= mag_a;
                den_reg    <= mag_b;
                neg_lo_reg <= req.is_signed && (op_a[31] ^ op_b[31]);
                neg_hi_reg <= req.is_signed &&
                              (req.is_div ? op_a[31] : (op_a[31] ^ op_b[31]));
            end else if (busy_reg) begin
                if (div_reg) begin
                    if (sum[33]) begin
                        hi_reg <= sum[31:0];
                        lo_reg <= {lo_reg[30:0], 1'b1};
                    end else begin
                        hi_reg <= opx[31:0];
                        lo_reg <= {lo_reg[30:0], 1'b0};
                    end
                end else if (lo_reg[0]) begin
                    hi_reg <= sum[32:1];
                    lo_reg <= {sum[0], lo_reg[31:1]};
                end else begin
                    hi_reg <= {1'b0, hi_reg[31:1]};
                    lo_reg <= {hi_reg[0], lo_reg[31:1]};
                end
                count_reg <= count_reg + 5'd1;
                if (count_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    fix_reg  <= 1'b1;
                end
            end else if (fix_reg) begin
                fix_reg  <= 1'b0;
                done_reg <= 1'b1;
                if (div_reg) begin
                    if (neg_lo_reg) lo_reg <= 32'd0 - lo_reg;
                    if (neg_hi_reg) hi_reg <= 32'd0 - hi_reg;
                end else if (neg_lo_reg) begin
                    {hi_reg, lo_reg} <= prod_neg;
                end
            end
        end
    end

    assign rsp = '{done: done_reg, hi: hi_reg, lo: lo_reg};

endmodule

`default_nettype wire

// File: hw/rtl/mips1_integer_core_execute.sv
// MIPS-I integer execute core top level: sequencer, decode, COP0 and PC state.
// Depends on m1ice_pkg, m1ice_ram (register file) and m1ice_muldiv.
`timescale 1ns / 1ps
`default_nettype none

// One request at a time is taken, executed and reported. A request is
// accepted in the idle cycle, which also starts the register file read; the
// next cycle executes it, and for an ordinary instruction or load return the
// result is offered in the cycle after that, held until m_ready. MULT, MULTU,
// DIV and DIVU run through the shared one-bit-per-cycle multiply/divide unit
// before the result is offered; a divide by zero skips the unit. Loads do
// not stall: a load issues a read result, and the data comes back as a
// separate load-return request. The register file is a RAM with valid bits,
// so no clearing pass is needed after reset.
module mips1_integer_core_execute #(
    parameter int COP0_REG_COUNT = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire m1ice_pkg::in_item_t s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output m1ice_pkg::out_item_t     m_data
);
    import m1ice_pkg::*;

    localparam int IDXW = $clog2(COP0_REG_COUNT);

    state_t      state_reg, state_next;
    in_item_t    item_reg;
    out_item_t   out_reg, out_next;
    logic [31:0] gpr_valid_reg;
    logic        va_reg, vb_reg;
    logic [4:0]  addr_a_reg, addr_b_reg;
    logic [31:0] pc_reg, pc_next, bd_reg, bd_next;
    logic        ds_reg, ds_next;
    logic [31:0] hi_reg, hi_next, lo_reg, lo_next;
    logic        load_wait_reg, load_wait_next;
    logic [4:0]  load_dest_reg, load_dest_next;
    logic [2:0]  load_form_reg, load_form_next;
    logic [1:0]  load_off_reg, load_off_next;
    logic [31:0] cop0_reg  [COP0_REG_COUNT];
    logic [31:0] cop0_next [COP0_REG_COUNT];

    logic [4:0]  raddr_a, raddr_b;
    logic [31:0] rdata_a, rdata_b, a, b;
    logic        wr_en, gpr_we;
    logic [4:0]  wr_idx;
    logic [31:0] wr_val;
    md_req_t     md_req;
    md_rsp_t     md_rsp;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_DONE);
    assign m_data  = out_reg;

    // A load return reads the pending destination for the LWL/LWR merge.
    assign raddr_a = s_data.mode ? load_dest_reg : s_data.instruction[25:21];
    assign raddr_b = s_data.instruction[20:16];
    assign gpr_we  = wr_en && (wr_idx != 5'd0);

    m1ice_ram #(.WIDTH(32), .DEPTH(32)) u_gpr (
        .aclk    (aclk),
        .we      (gpr_we),
        .waddr   (wr_idx),
        .wdata   (wr_val),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    m1ice_muldiv u_md (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .op_a    (a),
        .op_b    (b),
        .rsp     (md_rsp)
    );

    assign a = va_reg ? rdata_a : gpr_reset_value(addr_a_reg);
    assign b = vb_reg ? rdata_b : gpr_reset_value(addr_b_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            gpr_valid_reg <= 32'd0;
            pc_reg        <= PC_RESET;
            bd_reg        <= 32'd0;
            ds_reg        <= 1'b0;
            hi_reg        <= 32'd0;
            lo_reg        <= 32'd0;
            load_wait_reg <= 1'b0;
            load_dest_reg <= 5'd0;
            load_form_reg <= LF_LB;
            load_off_reg  <= 2'd0;
            for (int i = 0; i < COP0_REG_COUNT; i++) begin
                cop0_reg[i] <= 32'd0;
            end
            cop0_reg[IDXW'(CP0_SR)]   <= SR_RESET;
            cop0_reg[IDXW'(CP0_PRID)] <= PRID_RESET;
        end else begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            bd_reg        <= bd_next;
            ds_reg        <= ds_next;
            hi_reg        <= hi_next;
            lo_reg        <= lo_next;
            load_wait_reg <= load_wait_next;
            load_dest_reg <= load_dest_next;
            load_form_reg <= load_form_next;
            load_off_reg  <= load_off_next;
            for (int i = 0; i < COP0_REG_COUNT; i++) begin
                cop0_reg[i] <= cop0_next[i];
            end
            if (gpr_we) begin
                gpr_valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg   <= s_data;
            va_reg     <= gpr_valid_reg[raddr_a];
            vb_reg     <= gpr_valid_reg[raddr_b];
            addr_a_reg <= raddr_a;
            addr_b_reg <= raddr_b;
        end
        if (state_reg == ST_EXEC) begin
            out_reg <= out_next;
        end
    end

    always_comb begin
        logic [31:0] code, here, seq, imm, ea, target, old, d, st, st_n;
        logic [31:0] exc_cause, exc_epc;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, sa, sh;
        logic [1:0]  off;
        logic        take, trap, unk, exc_go;

        code = item_reg.instruction;
        op   = code[31:26];
        fn   = code[5:0];
        rs   = code[25:21];
        rt   = code[20:16];
        rd   = code[15:11];
        sa   = code[10:6];
        here = pc_reg;
        seq  = pc_reg + 32'd4;
        imm  = {{16{code[15]}}, code[15:0]};
        ea   = a + imm;
        off  = ea[1:0];
        old  = a;
        d    = item_reg.load_data;
        sh   = {load_off_reg, 3'b000};
        target    = 32'd0;
        take      = 1'b0;
        trap      = 1'b0;
        unk       = 1'b0;
        exc_go    = 1'b0;
        exc_cause = 32'd0;
        exc_epc   = 32'd0;
        st        = cop0_reg[IDXW'(CP0_SR)];
        st_n      = {st[31:6], st[3:0], 2'b00};

        state_next     = state_reg;
        pc_next        = pc_reg;
        bd_next        = bd_reg;
        ds_next        = ds_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        load_wait_next = load_wait_reg;
        load_dest_next = load_dest_reg;
        load_form_next = load_form_reg;
        load_off_next  = load_off_reg;
        for (int i = 0; i < COP0_REG_COUNT; i++) begin
            cop0_next[i] = cop0_reg[i];
        end
        out_next = '0;
        wr_en    = 1'b0;
        wr_idx   = rd;
        wr_val   = 32'd0;
        md_req   = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                if (item_reg.mode) begin
                    if (load_wait_reg) begin
                        load_wait_next = 1'b0;
                        wr_en  = 1'b1;
                        wr_idx = load_dest_reg;
                        case (load_form_reg)
                            LF_LB:   wr_val = {{24{d[7]}}, d[7:0]};
                            LF_LH:   wr_val = {{16{d[15]}}, d[15:0]};
                            LF_LWL:  wr_val = (old & (32'h00ff_ffff >> sh)) |
                                              (d << (5'd24 - sh));
                            LF_LBU:  wr_val = {24'd0, d[7:0]};
                            LF_LHU:  wr_val = {16'd0, d[15:0]};
                            LF_LWR:  wr_val = (old & (32'hffff_ff00 << (5'd24 - sh))) |
                                              (d >> sh);
                            default: wr_val = d;
                        endcase
                    end
                end else if (load_wait_reg) begin
                    // An instruction offered while a load is pending is dropped.
                end else if (!ds_reg && item_reg.irq_pending && st[10] &&
                             cop0_reg[IDXW'(CP0_CAUSE)][10] && st[0]) begin
                    exc_go    = 1'b1;
                    exc_cause = CAUSE_INT;
                    exc_epc   = pc_reg;
                end else begin
                    unique case (op)
                        OP_SPECIAL: begin
                            case (fn)
                                FN_SLL:  begin wr_en = 1'b1; wr_val = b << sa; end
                                FN_SRL:  begin wr_en = 1'b1; wr_val = b >> sa; end
                                FN_SRA:  begin wr_en = 1'b1; wr_val = 32'($signed(b) >>> sa); end
                                FN_SLLV: begin wr_en = 1'b1; wr_val = b << a[4:0]; end
                                FN_SRLV: begin wr_en = 1'b1; wr_val = b >> a[4:0]; end
                                FN_SRAV: begin
                                    wr_en  = 1'b1;
                                    wr_val = 32'($signed(b) >>> a[4:0]);
                                end
                                FN_JR:   begin take = 1'b1; target = a; end
                                FN_JALR: begin
                                    take = 1'b1; target = a;
                                    wr_en = 1'b1; wr_val = here + 32'd8;
                                end
                                FN_SYSCALL: trap = 1'b1;
                                FN_BREAK:   ;
                                FN_MFHI: begin wr_en = 1'b1; wr_val = hi_reg; end
                                FN_MTHI: hi_next = a;
                                FN_MFLO: begin wr_en = 1'b1; wr_val = lo_reg; end
                                FN_MTLO: lo_next = a;
                                FN_MULT, FN_MULTU, FN_DIV, FN_DIVU: begin
                                    // Divide by zero leaves HI and LO alone.
                                    md_req.is_div    = fn[1];
                                    md_req.is_signed = !fn[0];
                                    md_req.start     = !fn[1] || (b != 32'd0);
                                    if (md_req.start) state_next = ST_MULDIV;
                                end
                                FN_ADD, FN_ADDU: begin wr_en = 1'b1; wr_val = a + b; end
                                FN_SUB, FN_SUBU: begin wr_en = 1'b1; wr_val = a - b; end
                                FN_AND:  begin wr_en = 1'b1; wr_val = a & b; end
                                FN_OR:   begin wr_en = 1'b1; wr_val = a | b; end
                                FN_XOR:  begin wr_en = 1'b1; wr_val = a ^ b; end
                                FN_NOR:  begin wr_en = 1'b1; wr_val = ~(a | b); end
                                FN_SLT:  begin
                                    wr_en = 1'b1;
                                    wr_val = {31'd0, $signed(a) < $signed(b)};
                                end
                                FN_SLTU: begin wr_en = 1'b1; wr_val = {31'd0, a < b}; end
                                default: unk = 1'b1;
                            endcase
                        end
                        OP_REGIMM: begin
                            target = seq + {imm[29:0], 2'b00};
                            case (rt)
                                RT_BLTZ: take = a[31];
                                RT_BGEZ: take = !a[31];
                                RT_BLTZAL, RT_BGEZAL: begin
                                    take   = a[31] ^ rt[0];
                                    wr_en  = 1'b1;
                                    wr_idx = GPR_RA;
                                    wr_val = here + 32'd8;
                                end
                                default: unk = 1'b1;
                            endcase
                        end
                        OP_J, OP_JAL: begin
                            take   = 1'b1;
                            target = {seq[31:28], code[25:0], 2'b00};
                            if (op == OP_JAL) begin
                                wr_en  = 1'b1;
                                wr_idx = GPR_RA;
                                wr_val = here + 32'd8;
                            end
                        end
                        OP_BEQ:  begin take = (a == b); target = seq + {imm[29:0], 2'b00}; end
                        OP_BNE:  begin take = (a != b); target = seq + {imm[29:0], 2'b00}; end
                        OP_BLEZ: begin
                            take   = a[31] || (a == 32'd0);
                            target = seq + {imm[29:0], 2'b00};
                        end
                        OP_BGTZ: begin
                            take   = !a[31] && (a != 32'd0);
                            target = seq + {imm[29:0], 2'b00};
                        end
                        OP_ADDI, OP_ADDIU: begin
                            wr_en = 1'b1; wr_idx = rt; wr_val = a + imm;
                        end
                        OP_SLTI: begin
                            wr_en = 1'b1; wr_idx = rt;
                            wr_val = {31'd0, $signed(a) < $signed(imm)};
                        end
                        OP_SLTIU: begin
                            wr_en = 1'b1; wr_idx = rt; wr_val = {31'd0, a < imm};
                        end
                        OP_ANDI: begin
                            wr_en = 1'b1; wr_idx = rt; wr_val = a & {16'd0, code[15:0]};
                        end
                        OP_ORI: begin
                            wr_en = 1'b1; wr_idx = rt; wr_val = a | {16'd0, code[15:0]};
                        end
                        OP_XORI: begin
                            wr_en = 1'b1; wr_idx = rt; wr_val = a ^ {16'd0, code[15:0]};
                        end
                        OP_LUI: begin
                            wr_en = 1'b1; wr_idx = rt; wr_val = {code[15:0], 16'd0};
                        end
                        OP_COP0: begin
                            case (rs)
                                CP_MF: begin
                                    wr_en  = 1'b1;
                                    wr_idx = rt;
                                    wr_val = (32'(rd) < COP0_REG_COUNT) ?
                                             cop0_reg[rd[IDXW-1:0]] : 32'd0;
                                end
                                CP_MT: begin
                                    if (32'(rd) < COP0_REG_COUNT) begin
                                        cop0_next[rd[IDXW-1:0]] = b;
                                    end
                                end
                                CP_RFE: cop0_next[IDXW'(CP0_SR)] = {st[31:4], st[5:2]};
                                default: unk = 1'b1;
                            endcase
                        end
                        OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR: begin
                            load_form_next = op[2:0];
                            load_dest_next = rt;
                            load_off_next  = off;
                            load_wait_next = 1'b1;
                            out_next.request_kind = REQ_READ;
                            out_next.mem_address  = (op == OP_LWL || op == OP_LWR) ?
                                                    {ea[31:2], 2'b00} : ea;
                            if (op == OP_LB || op == OP_LBU) begin
                                out_next.access_size = SIZE_BYTE;
                            end else if (op == OP_LH || op == OP_LHU) begin
                                out_next.access_size = SIZE_HALF;
                            end else begin
                                out_next.access_size = SIZE_WORD;
                            end
                        end
                        OP_SB: begin
                            out_next.request_kind = REQ_WRITE;
                            out_next.mem_address  = ea;
                            out_next.access_size  = SIZE_BYTE;
                            out_next.byte_enable  = 4'b0001 << off;
                            out_next.write_data   = {24'd0, b[7:0]} << {off, 3'b000};
                        end
                        OP_SH: begin
                            out_next.request_kind = REQ_WRITE;
                            out_next.mem_address  = ea;
                            out_next.access_size  = SIZE_HALF;
                            out_next.byte_enable  = 4'b0011 << {off[1], 1'b0};
                            out_next.write_data   = {16'd0, b[15:0]} << {off[1], 4'b0000};
                        end
                        OP_SWL: begin
                            out_next.request_kind = REQ_WRITE;
                            out_next.mem_address  = {ea[31:2], 2'b00};
                            out_next.access_size  = SIZE_WORD;
                            out_next.byte_enable  = 4'((5'd2 << off) - 5'd1);
                            out_next.write_data   = b >> (5'd24 - {off, 3'b000});
                        end
                        OP_SW: begin
                            out_next.request_kind = REQ_WRITE;
                            out_next.mem_address  = ea;
                            out_next.access_size  = SIZE_WORD;
                            out_next.byte_enable  = 4'b1111;
                            out_next.write_data   = b;
                        end
                        OP_SWR: begin
                            out_next.request_kind = REQ_WRITE;
                            out_next.mem_address  = {ea[31:2], 2'b00};
                            out_next.access_size  = SIZE_WORD;
                            out_next.byte_enable  = 4'b1111 << off;
                            out_next.write_data   = b << {off, 3'b000};
                        end
                        default: unk = 1'b1;
                    endcase

                    // A syscall in a delay slot drops the branch and reports the branch's address.
                    if (trap) begin
                        exc_go    = 1'b1;
                        exc_cause = ds_reg ? (CAUSE_SYS | CAUSE_BD) : CAUSE_SYS;
                        exc_epc   = ds_reg ? (here - 32'd4) : here;
                    end else if (ds_reg) begin
                        pc_next = bd_reg;
                        ds_next = 1'b0;
                    end else begin
                        if (take) begin
                            ds_next = 1'b1;
                            bd_next = target;
                        end
                        pc_next = seq;
                    end
                    out_next.unknown_opcode = unk;
                end

                if (exc_go) begin
                    cop0_next[IDXW'(CP0_SR)]    = st_n;
                    cop0_next[IDXW'(CP0_CAUSE)] = exc_cause;
                    cop0_next[IDXW'(CP0_EPC)]   = exc_epc;
                    ds_next = 1'b0;
                    pc_next = st_n[18] ? VEC_BOOT : VEC_RAM;
                    out_next.exception_taken = 1'b1;
                end
                out_next.next_pc = pc_next;
            end
            ST_MULDIV: begin
                if (md_rsp.done) begin
                    hi_next    = md_rsp.hi;
                    lo_next    = md_rsp.lo;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/m1ice_checker.sv
// Port-level checker for the MIPS-I execute core, bound to the top level.
// Depends on m1ice_pkg for the payload structs and request codes.
`timescale 1ns / 1ps
`default_nettype none

module m1ice_checker (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire m1ice_pkg::in_item_t  s_data,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire m1ice_pkg::out_item_t m_data
);
    import m1ice_pkg::*;

    // The core holds one request at a time, so it never takes input while a
    // result is on offer.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while a result is pending");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.request_kind != 2'd3)
        else $error("illegal request kind");

    a_idle_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.request_kind == REQ_NONE |->
            m_data.mem_address == 32'd0 && m_data.byte_enable == 4'd0 &&
            m_data.write_data == 32'd0 && m_data.access_size == SIZE_BYTE)
        else $error("memory fields set without a memory request");

    a_read_no_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.request_kind == REQ_READ |->
            m_data.byte_enable == 4'd0 && m_data.write_data == 32'd0 &&
            !m_data.exception_taken)
        else $error("read request carries write fields");

endmodule

bind mips1_integer_core_execute m1ice_checker u_m1ice_checker (.*);

`default_nettype wire

// File: test/mips1_integer_core_execute_tb.sv
// Testbench for the MIPS-I integer execute core: directed and random requests.
// A class-based scoreboard predicts every result from its own copy of the state.
// Depends on m1ice_pkg and mips1_integer_core_execute.
`timescale 1ns / 1ps

class core_scoreboard;
    logic [31:0] gpr [32];
    logic [31:0] cp0 [32];
    logic [31:0] hi, lo, pc, br_dest;
    bit          in_delay, load_busy;
    logic [4:0]  ld_dest;
    logic [2:0]  ld_form;
    logic [1:0]  ld_off;
    m1ice_pkg::out_item_t expected_q[$];
    int          errors;

    function void reset_state();
        foreach (gpr[i]) gpr[i] = (i == 29) ? m1ice_pkg::SP_RESET : 32'd0;
        foreach (cp0[i]) cp0[i] = 32'd0;
        cp0[m1ice_pkg::CP0_SR]   = m1ice_pkg::SR_RESET;
        cp0[m1ice_pkg::CP0_PRID] = m1ice_pkg::PRID_RESET;
        hi = 0; lo = 0; pc = m1ice_pkg::PC_RESET; br_dest = 0;
        in_delay = 0; load_busy = 0; ld_dest = 0; ld_form = 0; ld_off = 0;
        expected_q.delete();
        errors = 0;
    endfunction

    function void set_gpr(logic [4:0] idx, logic [31:0] v);
        if (idx != 0) gpr[idx] = v;
    endfunction

    function void take_exception(logic [31:0] cause, logic [31:0] epc);
        logic [31:0] st;
        st = cp0[m1ice_pkg::CP0_SR];
        st = (st & ~32'h3f) | ((st << 2) & 32'h3f);
        cp0[m1ice_pkg::CP0_SR] = st;
        cp0[m1ice_pkg::CP0_CAUSE] = cause;
        cp0[m1ice_pkg::CP0_EPC] = epc;
        in_delay = 0;
        pc = st[18] ? m1ice_pkg::VEC_BOOT : m1ice_pkg::VEC_RAM;
    endfunction

    function void complete_load(logic [31:0] d);
        logic [31:0] old, v;
        int sh;
        old = gpr[ld_dest];
        sh = 8 * ld_off;
        case (ld_form)
            m1ice_pkg::LF_LB:  v = {{24{d[7]}}, d[7:0]};
            m1ice_pkg::LF_LH:  v = {{16{d[15]}}, d[15:0]};
            m1ice_pkg::LF_LWL: v = (old & (32'h00ffffff >> sh)) | (d << (24 - sh));
            m1ice_pkg::LF_LBU: v = {24'd0, d[7:0]};
            m1ice_pkg::LF_LHU: v = {16'd0, d[15:0]};
            m1ice_pkg::LF_LWR: v = (old & (32'hffffff00 << (24 - sh))) | (d >> sh);
            default:           v = d;
        endcase
        set_gpr(ld_dest, v);
    endfunction

    // Notes an accepted request and queues the result it should produce.
    function void note_request(m1ice_pkg::in_item_t req);
        m1ice_pkg::out_item_t r;
        logic [31:0] code, here, seq, a, b, imm, ea, target, q, rm, ma, mb;
        logic [4:0]  rs, rt, rd, sa;
        logic [5:0]  op, fn;
        logic [63:0] p;
        logic [1:0]  off;
        bit          slot, take, trap, unk;
        r = '0;
        take = 0; trap = 0; unk = 0; target = 0;
        if (req.mode) begin
            if (load_busy) begin
                complete_load(req.load_data);
                load_busy = 0;
            end
            r.next_pc = pc;
            expected_q.push_back(r);
            return;
        end
        if (load_busy) begin
            r.next_pc = pc;
            expected_q.push_back(r);
            return;
        end
        if (!in_delay && req.irq_pending && cp0[12][10] && cp0[13][10] && cp0[12][0]) begin
            take_exception(m1ice_pkg::CAUSE_INT, pc);
            r.next_pc = pc;
            r.exception_taken = 1;
            expected_q.push_back(r);
            return;
        end
        code = req.instruction;
        here = pc; seq = here + 4; slot = in_delay;
        op = code[31:26]; fn = code[5:0];
        rs = code[25:21]; rt = code[20:16]; rd = code[15:11]; sa = code[10:6];
        a = gpr[rs]; b = gpr[rt];
        imm = {{16{code[15]}}, code[15:0]};
        ea = a + imm; off = ea[1:0];
        case (op)
            m1ice_pkg::OP_SPECIAL: begin
                case (fn)
                    m1ice_pkg::FN_SLL:  set_gpr(rd, b << sa);
                    m1ice_pkg::FN_SRL:  set_gpr(rd, b >> sa);
                    m1ice_pkg::FN_SRA:  set_gpr(rd, $signed(b) >>> sa);
                    m1ice_pkg::FN_SLLV: set_gpr(rd, b << a[4:0]);
                    m1ice_pkg::FN_SRLV: set_gpr(rd, b >> a[4:0]);
                    m1ice_pkg::FN_SRAV: set_gpr(rd, $signed(b) >>> a[4:0]);
                    m1ice_pkg::FN_JR: begin
                        take = 1; target = a;
                    end
                    m1ice_pkg::FN_JALR: begin
                        take = 1; target = a; set_gpr(rd, here + 8);
                    end
                    m1ice_pkg::FN_SYSCALL: trap = 1;
                    m1ice_pkg::FN_BREAK: ;
                    m1ice_pkg::FN_MFHI: set_gpr(rd, hi);
                    m1ice_pkg::FN_MTHI: hi = a;
                    m1ice_pkg::FN_MFLO: set_gpr(rd, lo);
                    m1ice_pkg::FN_MTLO: lo = a;
                    m1ice_pkg::FN_MULT, m1ice_pkg::FN_MULTU: begin
                        if (fn == m1ice_pkg::FN_MULTU) p = {32'd0, a} * {32'd0, b};
                        else p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                        lo = p[31:0]; hi = p[63:32];
                    end
                    m1ice_pkg::FN_DIV: begin
                        if (b != 0) begin
                            ma = a[31] ? -a : a;
                            mb = b[31] ? -b : b;
                            q = ma / mb; rm = ma % mb;
                            lo = (a[31] != b[31]) ? -q : q;
                            hi = a[31] ? -rm : rm;
                        end
                    end
                    m1ice_pkg::FN_DIVU: begin
                        if (b != 0) begin
                            lo = a / b; hi = a % b;
                        end
                    end
                    m1ice_pkg::FN_ADD, m1ice_pkg::FN_ADDU: set_gpr(rd, a + b);
                    m1ice_pkg::FN_SUB, m1ice_pkg::FN_SUBU: set_gpr(rd, a - b);
                    m1ice_pkg::FN_AND: set_gpr(rd, a & b);
                    m1ice_pkg::FN_OR:  set_gpr(rd, a | b);
                    m1ice_pkg::FN_XOR: set_gpr(rd, a ^ b);
                    m1ice_pkg::FN_NOR: set_gpr(rd, ~(a | b));
                    m1ice_pkg::FN_SLT: set_gpr(rd, {31'd0, $signed(a) < $signed(b)});
                    m1ice_pkg::FN_SLTU: set_gpr(rd, {31'd0, a < b});
                    default: unk = 1;
                endcase
            end
            m1ice_pkg::OP_REGIMM: begin
                target = seq + (imm << 2);
                case (rt)
                    m1ice_pkg::RT_BLTZ: take = a[31];
                    m1ice_pkg::RT_BGEZ: take = !a[31];
                    m1ice_pkg::RT_BLTZAL: begin
                        take = a[31]; set_gpr(m1ice_pkg::GPR_RA, here + 8);
                    end
                    m1ice_pkg::RT_BGEZAL: begin
                        take = !a[31]; set_gpr(m1ice_pkg::GPR_RA, here + 8);
                    end
                    default: unk = 1;
                endcase
            end
            m1ice_pkg::OP_J, m1ice_pkg::OP_JAL: begin
                take = 1;
                target = {seq[31:28], code[25:0], 2'b00};
                if (op == m1ice_pkg::OP_JAL) set_gpr(m1ice_pkg::GPR_RA, here + 8);
            end
            m1ice_pkg::OP_BEQ: begin
                take = (a == b); target = seq + (imm << 2);
            end
            m1ice_pkg::OP_BNE: begin
                take = (a != b); target = seq + (imm << 2);
            end
            m1ice_pkg::OP_BLEZ: begin
                take = a[31] || a == 0; target = seq + (imm << 2);
            end
            m1ice_pkg::OP_BGTZ: begin
                take = !a[31] && a != 0; target = seq + (imm << 2);
            end
            m1ice_pkg::OP_ADDI, m1ice_pkg::OP_ADDIU: set_gpr(rt, a + imm);
            m1ice_pkg::OP_SLTI:  set_gpr(rt, {31'd0, $signed(a) < $signed(imm)});
            m1ice_pkg::OP_SLTIU: set_gpr(rt, {31'd0, a < imm});
            m1ice_pkg::OP_ANDI:  set_gpr(rt, a & {16'd0, code[15:0]});
            m1ice_pkg::OP_ORI:   set_gpr(rt, a | {16'd0, code[15:0]});
            m1ice_pkg::OP_XORI:  set_gpr(rt, a ^ {16'd0, code[15:0]});
            m1ice_pkg::OP_LUI:   set_gpr(rt, {code[15:0], 16'd0});
            m1ice_pkg::OP_COP0: begin
                if (rs == m1ice_pkg::CP_MF) set_gpr(rt, cp0[rd]);
                else if (rs == m1ice_pkg::CP_MT) cp0[rd] = b;
                else if (rs == m1ice_pkg::CP_RFE)
                    cp0[12] = (cp0[12] & ~32'hf) | ((cp0[12] >> 2) & 32'hf);
                else unk = 1;
            end
            m1ice_pkg::OP_LB, m1ice_pkg::OP_LH, m1ice_pkg::OP_LWL, m1ice_pkg::OP_LW,
            m1ice_pkg::OP_LBU, m1ice_pkg::OP_LHU, m1ice_pkg::OP_LWR: begin
                ld_form = op[2:0];
                ld_dest = rt; ld_off = off; load_busy = 1;
                r.request_kind = m1ice_pkg::REQ_READ;
                r.mem_address = (ld_form == m1ice_pkg::LF_LWL || ld_form == m1ice_pkg::LF_LWR)
                                ? {ea[31:2], 2'b00} : ea;
                case (ld_form)
                    m1ice_pkg::LF_LB, m1ice_pkg::LF_LBU: r.access_size = m1ice_pkg::SIZE_BYTE;
                    m1ice_pkg::LF_LH, m1ice_pkg::LF_LHU: r.access_size = m1ice_pkg::SIZE_HALF;
                    default: r.access_size = m1ice_pkg::SIZE_WORD;
                endcase
            end
            m1ice_pkg::OP_SB: begin
                r.request_kind = m1ice_pkg::REQ_WRITE; r.mem_address = ea;
                r.access_size = m1ice_pkg::SIZE_BYTE;
                r.byte_enable = 4'b0001 << off;
                r.write_data = {24'd0, b[7:0]} << (8 * off);
            end
            m1ice_pkg::OP_SH: begin
                r.request_kind = m1ice_pkg::REQ_WRITE; r.mem_address = ea;
                r.access_size = m1ice_pkg::SIZE_HALF;
                r.byte_enable = off[1] ? 4'b1100 : 4'b0011;
                r.write_data = off[1] ? {b[15:0], 16'd0} : {16'd0, b[15:0]};
            end
            m1ice_pkg::OP_SWL: begin
                r.request_kind = m1ice_pkg::REQ_WRITE; r.mem_address = {ea[31:2], 2'b00};
                r.access_size = m1ice_pkg::SIZE_WORD;
                r.byte_enable = 4'((5'd2 << off) - 5'd1);
                r.write_data = b >> (24 - 8 * off);
            end
            m1ice_pkg::OP_SW: begin
                r.request_kind = m1ice_pkg::REQ_WRITE; r.mem_address = ea;
                r.access_size = m1ice_pkg::SIZE_WORD;
                r.byte_enable = 4'hf; r.write_data = b;
            end
            m1ice_pkg::OP_SWR: begin
                r.request_kind = m1ice_pkg::REQ_WRITE; r.mem_address = {ea[31:2], 2'b00};
                r.access_size = m1ice_pkg::SIZE_WORD;
                r.byte_enable = 4'hf << off;
                r.write_data = b << (8 * off);
            end
            default: unk = 1;
        endcase
        if (trap) begin
            take_exception(slot ? (m1ice_pkg::CAUSE_SYS | m1ice_pkg::CAUSE_BD)
                                : m1ice_pkg::CAUSE_SYS, slot ? here - 4 : here);
            r.exception_taken = 1;
        end else if (slot) begin
            pc = br_dest;
            in_delay = 0;
        end else begin
            if (take) begin
                in_delay = 1; br_dest = target;
            end
            pc = seq;
        end
        r.next_pc = pc;
        r.unknown_opcode = unk;
        expected_q.push_back(r);
    endfunction

    function void check_result(m1ice_pkg::out_item_t got);
        m1ice_pkg::out_item_t want;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (got.request_kind !== want.request_kind)
            $display("%0t: request_kind expected %h actual %h", $time,
                     want.request_kind, got.request_kind);
        if (got.mem_address !== want.mem_address)
            $display("%0t: mem_address expected %h actual %h", $time,
                     want.mem_address, got.mem_address);
        if (got.access_size !== want.access_size)
            $display("%0t: access_size expected %h actual %h", $time,
                     want.access_size, got.access_size);
        if (got.byte_enable !== want.byte_enable)
            $display("%0t: byte_enable expected %h actual %h", $time,
                     want.byte_enable, got.byte_enable);
        if (got.write_data !== want.write_data)
            $display("%0t: write_data expected %h actual %h", $time,
                     want.write_data, got.write_data);
        if (got.next_pc !== want.next_pc)
            $display("%0t: next_pc expected %h actual %h", $time, want.next_pc, got.next_pc);
        if (got.exception_taken !== want.exception_taken)
            $display("%0t: exception_taken expected %b actual %b", $time,
                     want.exception_taken, got.exception_taken);
        if (got.unknown_opcode !== want.unknown_opcode)
            $display("%0t: unknown_opcode expected %b actual %b", $time,
                     want.unknown_opcode, got.unknown_opcode);
        if (got !== want) errors++;
    endfunction
endclass

module mips1_integer_core_execute_tb;
    import m1ice_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic      aclk = 0;
    logic      aresetn = 0;
    logic      s_valid = 0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 0;
    out_item_t m_data;

    core_scoreboard sb;
    bit  quiet_tail = 0;
    bit  hold_off = 0;
    bit  stim_done = 0;
    int  idle_cycles = 0;
    int  n_items = 0;

    mips1_integer_core_execute dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    function automatic logic [31:0] r_type(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                           logic [4:0] sa, logic [5:0] fn);
        return {OP_SPECIAL, rs, rt, rd, sa, fn};
    endfunction

    function automatic logic [31:0] i_type(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                           logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // Offers one request and holds it until the core accepts it. Valid stays
    // high into the next request unless an idle gap comes first.
    task automatic send_request(logic mode, logic [31:0] instr, logic irq, logic [31:0] ld);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_data  <= '{mode: mode, instruction: instr, irq_pending: irq, load_data: ld};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request('{mode: mode, instruction: instr, irq_pending: irq, load_data: ld});
        n_items++;
    endtask

    task automatic exec(logic [31:0] instr, logic irq = 0);
        send_request(0, instr, irq, $urandom);
    endtask

    // Sends a load return only when the predictor has a load outstanding.
    task automatic return_load(logic [31:0] data);
        if (sb.load_busy) send_request(1, $urandom, $urandom_range(0, 1), data);
    endtask

    function automatic logic [31:0] random_instr();
        logic [5:0] ops[] = '{OP_SPECIAL, OP_SPECIAL, OP_SPECIAL, OP_REGIMM, OP_J, OP_JAL,
            OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU,
            OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_COP0, OP_LB, OP_LH, OP_LWL, OP_LW,
            OP_LBU, OP_LHU, OP_LWR, OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR};
        logic [5:0] fns[] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR,
            FN_JALR, FN_SYSCALL, FN_BREAK, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT,
            FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR,
            FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
        logic [4:0] cps[] = '{CP_MF, CP_MF, CP_MT, CP_RFE};
        logic [31:0] w;
        logic [5:0] op;
        w = $urandom;
        if ($urandom_range(0, 19) == 0) return w;
        op = ops[$urandom_range(0, ops.size() - 1)];
        w[31:26] = op;
        if (op == OP_SPECIAL) w[5:0] = fns[$urandom_range(0, fns.size() - 1)];
        // Keep SR writes rare so the interrupt and vector bits do not churn.
        if (op == OP_COP0) begin
            w[25:21] = cps[$urandom_range(0, 3)];
            if (w[25:21] == CP_MT && w[15:11] == 5'(CP0_SR) && $urandom_range(0, 3) != 0)
                w[15:11] = 5'd3;
        end
        return w;
    endfunction

    initial begin
        sb = new();
        sb.reset_state();
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: operands at the extremes and a selection of opcode classes and corner cases.
        exec(i_type(OP_LUI, 0, 1, 16'h8000));
        exec(i_type(OP_ADDIU, 0, 2, 16'hffff));
        exec(r_type(1, 2, 3, 0, FN_DIV));
        exec(r_type(1, 0, 3, 0, FN_DIVU));
        exec(r_type(1, 2, 0, 0, FN_MULT));
        exec(r_type(1, 2, 4, 0, FN_MULTU));
        exec(r_type(0, 2, 5, 5'd31, FN_SRA));
        exec(i_type(OP_SLTIU, 0, 6, 16'h8000));
        exec(i_type(OP_COP0, CP_MF, 7, 16'(CP0_PRID) << 11));
        exec(i_type(OP_COP0, CP_MT, 2, 16'd31 << 11));
        exec(i_type(OP_COP0, 5'd8, 0, 0));
        exec(i_type(OP_BEQ, 0, 0, 16'h0004));
        exec(r_type(0, 0, 0, 0, FN_SYSCALL));
        exec(i_type(OP_COP0, CP_RFE, 0, 0));
        exec(i_type(OP_BNE, 0, 2, 16'hfffc));
        exec({OP_REGIMM, 5'd1, RT_BLTZAL, 16'h0010});
        exec(r_type(0, 0, 0, 0, FN_BREAK));
        exec(i_type(OP_SWL, 2, 1, 16'h0002));
        exec(i_type(OP_SH, 2, 1, 16'h0003));
        exec(i_type(OP_LWL, 29, 2, 16'h0001));
        exec(32'hffff_ffff);
        return_load(32'hdead_beef);
        exec(i_type(OP_LWR, 29, 2, 16'h0002));
        return_load(32'hffff_ffff);
        exec({6'd18, 26'd0});
        send_request(1, 0, 0, 0);

        // Open the interrupt path: SR gets IM2 and IEc, CAUSE gets IP2.
        exec(i_type(OP_ORI, 0, 8, 16'h0401));
        exec(i_type(OP_COP0, CP_MT, 8, 16'(CP0_SR) << 11));
        exec(i_type(OP_COP0, CP_MT, 8, 16'(CP0_CAUSE) << 11));
        exec(0, 1);
        exec(i_type(OP_COP0, CP_RFE, 0, 0), 0);

        for (int i = 0; i < 880; i++) begin
            logic [31:0] w;
            if (i > 780) quiet_tail = 1;
            if (i == 400) hold_off = 1;
            w = random_instr();
            if ($urandom_range(0, 15) == 0) send_request(1, $urandom, 0, $urandom);
            exec(w, $urandom_range(0, 9) == 0);
            if (sb.load_busy) begin
                if ($urandom_range(0, 9) == 0) exec(random_instr());
                return_load($urandom);
            end
            // Seed a fresh register now and then so operands stay varied.
            if ($urandom_range(0, 5) == 0)
                exec(i_type(OP_LUI, 0, 5'($urandom_range(1, 31)), 16'($urandom)));
        end
        s_valid <= 0;
        stim_done = 1;
    end

    // Receiver: random stall bursts plus one long hold-off.
    initial begin
        int stall;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_ready <= 0;
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 8);
                m_ready <= 0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        if (aresetn && !((s_valid && s_ready) || (m_valid && m_ready))) idle_cycles++;
        else idle_cycles = 0;
    end

    initial begin
        wait (stim_done && sb.expected_q.size() == 0);
        repeat (60) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/m1ice_pkg.sv
hw/rtl/m1ice_ram.sv
hw/rtl/m1ice_muldiv.sv
hw/rtl/mips1_integer_core_execute.sv
hw/rtl/m1ice_checker.sv
test/mips1_integer_core_execute_tb.sv
